@@ rtl/fgn_pkg.sv @@
// fgn_pkg: shared types, constants and arithmetic helpers of the fractal noise unit
// depends on nothing; used by the octave cells, the divider cells and the top level
`default_nettype none
package fgn_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_OCTAVES = 8;

  // quotient bits of the normalizing divider, one divider cell each
  localparam int DIV_STEPS   = 17;

  localparam logic [16:0] ONE        = 17'h10000;
  localparam logic [30:0] FREQ_LIMIT = 31'h7fff_ffff;

  // corner hash multipliers
  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

  // configuration register indexes
  localparam logic [1:0] REG_SEED    = 2'd0;
  localparam logic [1:0] REG_OCTAVES = 2'd1;
  localparam logic [1:0] REG_PERSIST = 2'd2;
  localparam logic [1:0] REG_LACUN   = 2'd3;

  // per-sample bundle handed from one octave cell to the next
  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        seed;
    logic [3:0]         count;
    logic [15:0]        pers;
    logic [23:0]        lac;
    logic [30:0]        freq;
    logic [16:0]        amp;
    logic [19:0]        amp_sum;
    logic signed [39:0] total;
  } fgn_bus_t;

  // per-sample bundle of the normalizing divider
  typedef struct packed {
    logic [39:0] num;
    logic [19:0] den;
    logic [16:0] quo;
    logic        zero;
    logic        sat;
  } fgn_div_t;

  // low byte of the mixed corner hash; only the low byte of the last product is kept
  function automatic logic [7:0] hash_byte(logic [31:0] seed, logic [31:0] px,
                                           logic [31:0] py);
    logic [31:0] h;
    logic [31:0] g;
    logic [15:0] m;
    h = seed ^ px ^ py;
    g = h ^ (h >> 13);
    m = g[7:0] * HASH_MUL_MIX[7:0];
    return m[7:0];
  endfunction

  // diagonal gradient picked by the low three hash bits
  function automatic logic signed [18:0] grad(logic [2:0] sel, logic signed [17:0] x,
                                              logic signed [17:0] y);
    logic signed [18:0] u;
    logic signed [18:0] v;
    logic signed [18:0] su;
    logic signed [18:0] sv;
    u  = sel[2] ? 19'(y) : 19'(x);
    v  = sel[2] ? 19'(x) : 19'(y);
    su = sel[0] ? -u : u;
    sv = sel[1] ? -v : v;
    return su + sv;
  endfunction

  // t times x in Q.16, rounded half up
  function automatic logic signed [23:0] rmul(logic [15:0] t, logic signed [23:0] x);
    logic signed [40:0] p;
    p = $signed({1'b0, t}) * x;
    p = p + 41'sd32768;
    return p[39:16];
  endfunction

  // linear blend of two corner values, rounded
  function automatic logic signed [19:0] blend(logic signed [18:0] a, logic signed [18:0] b,
                                               logic [16:0] w);
    logic signed [38:0] s;
    logic [16:0]        wc;
    wc = ONE - w;
    s  = a * $signed({1'b0, wc}) + b * $signed({1'b0, w});
    s  = s + 39'sd32768;
    return s[35:16];
  endfunction

endpackage
`default_nettype wire

@@ rtl/fgn_coord_if.sv @@
// fgn_coord_if: valid/ready channel carrying one sample coordinate pair
// depends on nothing
`default_nettype none
interface fgn_coord_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface
`default_nettype wire

@@ rtl/fgn_noise_if.sv @@
// fgn_noise_if: valid/ready channel carrying one normalized noise value
// depends on nothing
`default_nettype none
interface fgn_noise_if;
  logic        valid;
  logic        ready;
  logic [16:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

@@ rtl/fgn_octave_cell.sv @@
// fgn_octave_cell: one noise octave as an eight-stage pipeline slice
// depends on fgn_pkg (bundle type, hash, gradient, fade and blend helpers)
`default_nettype none
module fgn_octave_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic [2:0]       octave,
  input  wire logic             valid_in,
  input  wire fgn_pkg::fgn_bus_t bus_in,
  output logic                  valid_out,
  output fgn_pkg::fgn_bus_t     bus_out
);

  // bundle and valid carried along the slice
  fgn_pkg::fgn_bus_t bus_q [1:8];
  logic [8:1]        vld;

  // stage payloads
  logic [31:0]        xi1, yi1;
  logic [15:0]        xf1, yf1, xf2, yf2, xf3, yf3, xf4, yf4;
  logic [31:0]        pxm2, pym2;
  logic signed [23:0] bu2, bv2, cu3, cv3, du4, dv4;
  logic [7:0]         h00_3, h01_3, h10_3, h11_3;
  logic signed [18:0] g00_4, g01_4, g10_4, g11_4, g00_5, g01_5, g10_5, g11_5;
  logic [16:0]        u5, v5, v6;
  logic signed [19:0] x1_6, x2_6, oct7;

  // stage 1 combinational
  logic signed [63:0] prod_x, prod_y;
  logic [54:0]        freq_prod;
  logic [38:0]        freq_next;
  fgn_pkg::fgn_bus_t  bus1_next;
  // stage 2 combinational
  logic signed [23:0] au, av;
  // stage 5 combinational
  logic signed [23:0] eu, ev;
  // stage 7 combinational
  logic signed [39:0] mix;
  logic [16:0]        vc;
  // stage 8 combinational
  logic signed [37:0] weighted;
  logic [32:0]        amp_prod;
  logic               active;
  fgn_pkg::fgn_bus_t  bus8_next;

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[7:1], valid_in};
    end
  end

  // stage 1: scale coordinate by frequency, step the frequency
  always_comb begin
    prod_x    = bus_in.cx * $signed({1'b0, bus_in.freq});
    prod_y    = bus_in.cy * $signed({1'b0, bus_in.freq});
    freq_prod = bus_in.freq * bus_in.lac + 55'd32768;
    freq_next = freq_prod[54:16];
    bus1_next = bus_in;
    bus1_next.freq = (freq_next > 39'(fgn_pkg::FREQ_LIMIT)) ? fgn_pkg::FREQ_LIMIT
                                                            : freq_next[30:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_q[1] <= bus1_next;
      xi1 <= prod_x[63:32];
      yi1 <= prod_y[63:32];
      xf1 <= prod_x[31:16];
      yf1 <= prod_y[31:16];
    end
  end

  // stage 2: hash products, first fade step
  always_comb begin
    au = $signed({8'd0, xf1}) * 24'sd6 - 24'sd983040;
    av = $signed({8'd0, yf1}) * 24'sd6 - 24'sd983040;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_q[2] <= bus_q[1];
      pxm2 <= xi1 * fgn_pkg::HASH_MUL_X;
      pym2 <= yi1 * fgn_pkg::HASH_MUL_Y;
      bu2  <= fgn_pkg::rmul(xf1, au) + 24'sd655360;
      bv2  <= fgn_pkg::rmul(yf1, av) + 24'sd655360;
      xf2  <= xf1;
      yf2  <= yf1;
    end
  end

  // stage 3: corner hashes, second fade step
  always_ff @(posedge clk) begin
    if (adv) begin
      bus_q[3] <= bus_q[2];
      h00_3 <= fgn_pkg::hash_byte(bus_q[2].seed, pxm2, pym2);
      h01_3 <= fgn_pkg::hash_byte(bus_q[2].seed, pxm2, pym2 + fgn_pkg::HASH_MUL_Y);
      h10_3 <= fgn_pkg::hash_byte(bus_q[2].seed, pxm2 + fgn_pkg::HASH_MUL_X, pym2);
      h11_3 <= fgn_pkg::hash_byte(bus_q[2].seed, pxm2 + fgn_pkg::HASH_MUL_X,
                                  pym2 + fgn_pkg::HASH_MUL_Y);
      cu3 <= fgn_pkg::rmul(xf2, bu2);
      cv3 <= fgn_pkg::rmul(yf2, bv2);
      xf3 <= xf2;
      yf3 <= yf2;
    end
  end

  // stage 4: corner gradients, third fade step
  always_ff @(posedge clk) begin
    if (adv) begin
      bus_q[4] <= bus_q[3];
      g00_4 <= fgn_pkg::grad(h00_3[2:0], $signed({2'b00, xf3}), $signed({2'b00, yf3}));
      g10_4 <= fgn_pkg::grad(h10_3[2:0], $signed({2'b11, xf3}), $signed({2'b00, yf3}));
      g01_4 <= fgn_pkg::grad(h01_3[2:0], $signed({2'b00, xf3}), $signed({2'b11, yf3}));
      g11_4 <= fgn_pkg::grad(h11_3[2:0], $signed({2'b11, xf3}), $signed({2'b11, yf3}));
      du4 <= fgn_pkg::rmul(xf3, cu3);
      dv4 <= fgn_pkg::rmul(yf3, cv3);
      xf4 <= xf3;
      yf4 <= yf3;
    end
  end

  // stage 5: last fade step with clamp to 0..one
  always_comb begin
    eu = fgn_pkg::rmul(xf4, du4);
    ev = fgn_pkg::rmul(yf4, dv4);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_q[5] <= bus_q[4];
      g00_5 <= g00_4;
      g01_5 <= g01_4;
      g10_5 <= g10_4;
      g11_5 <= g11_4;
      if (eu < 0) begin
        u5 <= '0;
      end else if (eu > 24'sd65536) begin
        u5 <= fgn_pkg::ONE;
      end else begin
        u5 <= eu[16:0];
      end
      if (ev < 0) begin
        v5 <= '0;
      end else if (ev > 24'sd65536) begin
        v5 <= fgn_pkg::ONE;
      end else begin
        v5 <= ev[16:0];
      end
    end
  end

  // stage 6: blend along x
  always_ff @(posedge clk) begin
    if (adv) begin
      bus_q[6] <= bus_q[5];
      x1_6 <= fgn_pkg::blend(g00_5, g10_5, u5);
      x2_6 <= fgn_pkg::blend(g01_5, g11_5, u5);
      v6   <= v5;
    end
  end

  // stage 7: blend along y and map to 0..1
  always_comb begin
    vc  = fgn_pkg::ONE - v6;
    mix = x1_6 * $signed({1'b0, vc}) + x2_6 * $signed({1'b0, v6}) + 40'sd4295032832;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_q[7] <= bus_q[6];
      oct7 <= mix[36:17];
    end
  end

  // stage 8: weight, accumulate, step amplitude and seed
  always_comb begin
    active   = {1'b0, octave} < bus_q[7].count;
    weighted = oct7 * $signed({1'b0, bus_q[7].amp});
    amp_prod = bus_q[7].amp * bus_q[7].pers + 33'd32768;
    bus8_next      = bus_q[7];
    bus8_next.seed = bus_q[7].seed + 32'd1;
    bus8_next.amp  = amp_prod[32:16];
    if (active) begin
      bus8_next.total   = bus_q[7].total + 40'(weighted);
      bus8_next.amp_sum = bus_q[7].amp_sum + 20'(bus_q[7].amp);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bus_q[8] <= bus8_next;
    end
  end

  assign valid_out = vld[8];
  assign bus_out   = bus_q[8];

endmodule
`default_nettype wire

@@ rtl/fgn_div_cell.sv @@
// fgn_div_cell: one restoring-division step producing one quotient bit
// depends on fgn_pkg (divider bundle type)
`default_nettype none
module fgn_div_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire logic [4:0]       bit_idx,
  input  wire logic             valid_in,
  input  wire fgn_pkg::fgn_div_t div_in,
  output logic                  valid_out,
  output fgn_pkg::fgn_div_t     div_out
);

  logic [39:0]       trial;
  fgn_pkg::fgn_div_t div_next;

  assign trial = 40'(div_in.den) << bit_idx;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
    end
  end

  // subtract shifted divisor when it fits
  always_comb begin
    div_next = div_in;
    if (div_in.num >= trial) begin
      div_next.num          = div_in.num - trial;
      div_next.quo[bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_out <= div_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fractal_gradient_noise_unit.sv @@
// fractal_gradient_noise_unit: top level, config registers, octave chain, divider chain
// depends on fgn_pkg, fgn_coord_if, fgn_noise_if, fgn_octave_cell, fgn_div_cell
//
//   channel  dir  payload                      transfer when
//   coord    in   coord_x, coord_y (Q16.16)    coord.valid & coord.ready
//   noise    out  noise_value (Q1.16)          noise.valid & noise.ready
//   cfg      in   cfg_idx, cfg_data            cfg_we
//
// one sample per cycle while the output is not stalled; stages: eight octave cells of eight stages,
// one divider setup stage, seventeen divider cells and the output register
// the whole pipeline advances together whenever the output register is empty or
// its transfer completes; while it stalls everything holds and bubbles stay in place
// reset clears all valid bits and loads the register defaults
`default_nettype none
module fractal_gradient_noise_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  fgn_coord_if.sink        coord,
  fgn_noise_if.source      noise
);

  logic [31:0] noise_seed;
  logic [3:0]  octave_count;
  logic [15:0] persistence_gain;
  logic [23:0] lacunarity_gain;

  logic adv;

  fgn_pkg::fgn_bus_t bus_in;
  fgn_pkg::fgn_bus_t bus_chain [0:fgn_pkg::MAX_OCTAVES];
  logic [fgn_pkg::MAX_OCTAVES:0] vld_chain;

  fgn_pkg::fgn_div_t div_chain [0:fgn_pkg::DIV_STEPS];
  logic [fgn_pkg::DIV_STEPS:0] div_vld;

  logic [39:0] num_next;
  logic [36:0] sat_lim;
  fgn_pkg::fgn_bus_t bus_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_seed       <= '0;
      octave_count     <= 4'd6;
      persistence_gain <= 16'd32768;
      lacunarity_gain  <= 24'd131072;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fgn_pkg::REG_SEED:    noise_seed       <= cfg_data;
        fgn_pkg::REG_OCTAVES: octave_count     <= cfg_data[3:0];
        fgn_pkg::REG_PERSIST: persistence_gain <= cfg_data[15:0];
        fgn_pkg::REG_LACUN:   lacunarity_gain  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign adv         = !noise.valid || noise.ready;
  assign coord.ready = adv;

  // bundle for the first octave
  always_comb begin
    bus_in.cx   = coord.coord_x;
    bus_in.cy   = coord.coord_y;
    bus_in.seed = noise_seed;
    if (octave_count == 4'd0) begin
      bus_in.count = 4'd1;
    end else if (octave_count > 4'(fgn_pkg::MAX_OCTAVES)) begin
      bus_in.count = 4'(fgn_pkg::MAX_OCTAVES);
    end else begin
      bus_in.count = octave_count;
    end
    bus_in.pers    = persistence_gain;
    bus_in.lac     = lacunarity_gain;
    bus_in.freq    = 31'(fgn_pkg::ONE);
    bus_in.amp     = fgn_pkg::ONE;
    bus_in.amp_sum = '0;
    bus_in.total   = '0;
  end

  assign bus_chain[0] = bus_in;
  assign vld_chain[0] = coord.valid;

  // octave cells
  for (genvar i = 0; i < fgn_pkg::MAX_OCTAVES; i++) begin : g_oct
    fgn_octave_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .octave    (3'(i)),
      .valid_in  (vld_chain[i]),
      .bus_in    (bus_chain[i]),
      .valid_out (vld_chain[i+1]),
      .bus_out   (bus_chain[i+1])
    );
  end

  // divider setup: rounding offset, sign and saturation checks
  assign bus_last = bus_chain[fgn_pkg::MAX_OCTAVES];
  assign num_next = bus_last.total + 40'(bus_last.amp_sum >> 1);
  assign sat_lim  = {1'b0, bus_last.amp_sum, 16'd0} + 37'(bus_last.amp_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else if (adv) begin
      div_vld[0] <= vld_chain[fgn_pkg::MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_chain[0].num  <= num_next;
      div_chain[0].den  <= bus_last.amp_sum;
      div_chain[0].quo  <= '0;
      div_chain[0].zero <= (bus_last.total <= 0);
      div_chain[0].sat  <= (num_next >= 40'(sat_lim));
    end
  end

  // divider cells, most significant quotient bit first
  for (genvar k = 0; k < fgn_pkg::DIV_STEPS; k++) begin : g_div
    fgn_div_cell u_div (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .bit_idx   (5'(fgn_pkg::DIV_STEPS - 1 - k)),
      .valid_in  (div_vld[k]),
      .div_in    (div_chain[k]),
      .valid_out (div_vld[k+1]),
      .div_out   (div_chain[k+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      noise.valid <= 1'b0;
    end else if (adv) begin
      noise.valid <= div_vld[fgn_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      priority if (div_chain[fgn_pkg::DIV_STEPS].zero) begin
        noise.noise_value <= '0;
      end else if (div_chain[fgn_pkg::DIV_STEPS].sat) begin
        noise.noise_value <= fgn_pkg::ONE;
      end else begin
        noise.noise_value <= div_chain[fgn_pkg::DIV_STEPS].quo;
      end
    end
  end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// tb: self-checking bench for fractal_gradient_noise_unit, fractal noise over config sweeps
// depends on fgn_pkg, fgn_coord_if, fgn_noise_if and the unit itself
// an octave-by-octave predictor checks every noise transfer in order
`default_nettype none
module tb;

  localparam longint Q_ONE = 64'sd65536;
  localparam int STALL_MAX = 18;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } coord_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [31:0] cfg_data;

  fgn_coord_if coord_ch ();
  fgn_noise_if noise_ch ();

  fractal_gradient_noise_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .coord    (coord_ch.sink),
    .noise    (noise_ch.source)
  );

  // shadow of the configuration registers
  logic [31:0] seed_q;
  logic [3:0]  octaves_q;
  logic [15:0] persist_q;
  logic [23:0] lacun_q;

  coord_t      coord_q[$];
  logic [16:0] noise_q[$];
  bit          quiet;
  bit          failed;
  int          idle_cycles;

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // round half up of v / 2^16
  function automatic longint rnd16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  // quintic fade, clamped to 0..1
  function automatic longint fade(longint t);
    longint a;
    longint b;
    longint e;
    a = 6 * t - 15 * Q_ONE;
    b = rnd16(t * a) + 10 * Q_ONE;
    e = rnd16(t * rnd16(t * rnd16(t * b)));
    if (e < 0) e = 0;
    if (e > Q_ONE) e = Q_ONE;
    return e;
  endfunction

  function automatic logic [7:0] corner_byte(logic [31:0] seed, logic [31:0] px,
                                            logic [31:0] py);
    logic [31:0] h;
    logic [31:0] mx;
    logic [31:0] my;
    mx = px * fgn_pkg::HASH_MUL_X;
    my = py * fgn_pkg::HASH_MUL_Y;
    h  = seed ^ mx ^ my;
    h  = h ^ (h >> 13);
    h  = h * fgn_pkg::HASH_MUL_MIX;
    return h[7:0];
  endfunction

  function automatic longint diag_grad(logic [7:0] hv, longint x, longint y);
    longint u;
    longint v;
    u = hv[2] ? y : x;
    v = hv[2] ? x : y;
    if (hv[0]) u = -u;
    if (hv[1]) v = -v;
    return u + v;
  endfunction

  function automatic longint mix_lin(longint a, longint b, longint w);
    return rnd16(a * (Q_ONE - w) + b * w);
  endfunction

  // expected noise value for one coordinate under the shadow config
  function automatic logic [16:0] fbm_noise(logic signed [31:0] x, logic signed [31:0] y);
    longint cx;
    longint cy;
    longint freq;
    longint amp;
    longint amp_sum;
    longint total;
    longint sx;
    longint sy;
    longint xf;
    longint yf;
    longint u;
    longint v;
    longint x1;
    longint x2;
    longint res;
    logic [31:0] xi;
    logic [31:0] yi;
    logic [31:0] s;
    int n;
    cx = x;
    cy = y;
    n = int'(octaves_q);
    if (n == 0) n = 1;
    if (n > fgn_pkg::MAX_OCTAVES) n = fgn_pkg::MAX_OCTAVES;
    freq = Q_ONE;
    amp = Q_ONE;
    amp_sum = 0;
    total = 0;
    for (int i = 0; i < n; i++) begin
      sx = (cx * freq) >>> 16;
      sy = (cy * freq) >>> 16;
      xi = 32'(sx >>> 16);
      yi = 32'(sy >>> 16);
      xf = sx & 64'sd65535;
      yf = sy & 64'sd65535;
      u = fade(xf);
      v = fade(yf);
      s = seed_q + 32'(i);
      x1 = mix_lin(diag_grad(corner_byte(s, xi, yi), xf, yf),
                   diag_grad(corner_byte(s, xi + 1, yi), xf - Q_ONE, yf), u);
      x2 = mix_lin(diag_grad(corner_byte(s, xi, yi + 1), xf, yf - Q_ONE),
                   diag_grad(corner_byte(s, xi + 1, yi + 1), xf - Q_ONE, yf - Q_ONE), u);
      total += ((x1 * (Q_ONE - v) + x2 * v + (Q_ONE << 16) + 64'sd65536) >>> 17) * amp;
      amp_sum += amp;
      amp = rnd16(amp * longint'(persist_q));
      freq = (freq * longint'(lacun_q) + 64'sd32768) >>> 16;
      if (freq > 64'sd2147483647) freq = 64'sd2147483647;
    end
    if (total <= 0) begin
      res = 0;
    end else begin
      res = (total + amp_sum / 2) / amp_sum;
      if (res > Q_ONE) res = Q_ONE;
    end
    return 17'(res);
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, STALL_MAX);
  endfunction

  // coordinate driver
  int gap_cnt;
  always @(posedge clk) begin
    coord_t c;
    logic nxt_valid;
    int g;
    if (rst) begin
      coord_ch.valid   <= 1'b0;
      coord_ch.coord_x <= '0;
      coord_ch.coord_y <= '0;
      gap_cnt <= 0;
    end else begin
      nxt_valid = coord_ch.valid;
      if (coord_ch.valid && coord_ch.ready) begin
        noise_q.insert(noise_q.size(), fbm_noise(coord_ch.coord_x, coord_ch.coord_y));
        g = draw_gap();
        if (g == 0 && coord_q.size() != 0) begin
          // back-to-back transfer when no gap is drawn
          c = coord_q.pop_front();
          coord_ch.coord_x <= c.x;
          coord_ch.coord_y <= c.y;
          gap_cnt <= 0;
        end else begin
          nxt_valid = 1'b0;
          gap_cnt <= (g > 0) ? g - 1 : 0;
        end
      end else if (!coord_ch.valid && gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
      end else if (!coord_ch.valid && coord_q.size() != 0) begin
        c = coord_q.pop_front();
        coord_ch.coord_x <= c.x;
        coord_ch.coord_y <= c.y;
        nxt_valid = 1'b1;
      end
      coord_ch.valid <= nxt_valid;
    end
  end

  // noise monitor and checker
  int stall_cnt;
  always @(posedge clk) begin
    logic [16:0] want;
    int g;
    if (rst) begin
      noise_ch.ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (noise_ch.valid && noise_ch.ready) begin
        if (noise_q.size() == 0) begin
          $error("unexpected noise transfer, noise_value %0d", noise_ch.noise_value);
          failed = 1'b1;
        end else begin
          want = noise_q.pop_front();
          if (noise_ch.noise_value !== want) begin
            $error("noise_value mismatch: expected %0d, actual %0d", want,
                   noise_ch.noise_value);
            failed = 1'b1;
          end
        end
        g = draw_gap();
        stall_cnt <= g;
        noise_ch.ready <= (g == 0);
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        noise_ch.ready <= (stall_cnt == 1);
      end else begin
        noise_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (coord_ch.valid && coord_ch.ready) || (noise_ch.valid && noise_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      fgn_pkg::REG_SEED:    seed_q    = val;
      fgn_pkg::REG_OCTAVES: octaves_q = val[3:0];
      fgn_pkg::REG_PERSIST: persist_q = val[15:0];
      default:              lacun_q   = val[23:0];
    endcase
  endtask

  task automatic set_config(logic [31:0] seed, logic [3:0] oct, logic [15:0] pers,
                            logic [23:0] lac);
    write_reg(fgn_pkg::REG_SEED, seed);
    write_reg(fgn_pkg::REG_OCTAVES, {28'h0, oct});
    write_reg(fgn_pkg::REG_PERSIST, {16'h0, pers});
    write_reg(fgn_pkg::REG_LACUN, {8'h0, lac});
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32 << 16)) - (16 << 16));
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic add_item(logic [31:0] x, logic [31:0] y);
    coord_t c;
    c.x = x;
    c.y = y;
    coord_q.insert(coord_q.size(), c);
  endtask

  // every accepted coordinate has produced its noise value
  task automatic drain();
    while (coord_q.size() != 0 || coord_ch.valid || noise_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    quiet = ($urandom_range(0, 3) == 0);
    repeat (n) add_item(rand_coord(), rand_coord());
    drain();
  endtask

  // stimulus
  initial begin
    logic [31:0] edges[10];
    failed   = 1'b0;
    quiet    = 1'b1;
    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_idx  = fgn_pkg::REG_SEED;
    cfg_data = '0;
    seed_q    = 32'd0;
    octaves_q = 4'd6;
    persist_q = 16'd32768;
    lacun_q   = 24'd131072;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corners of the coordinate range under reset config
    edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1, 32'h8000,
              32'hffff, 32'h10000, 32'hffff0000, 32'h00018000};
    for (int i = 0; i < 10; i++) add_item(edges[i], edges[9 - i]);
    for (int i = 0; i < 10; i++) add_item(edges[i], edges[i]);
    drain();
    random_phase(40);

    // one octave, zero persistence, full seed
    set_config(32'hffffffff, 4'd1, 16'd0, 24'd131072);
    random_phase(45);
    // octave count zero counts as one
    set_config(32'd0, 4'd0, 16'd65535, 24'd0);
    random_phase(45);
    // count above the limit, frequency saturating
    set_config($urandom(), 4'd15, 16'd65535, 24'hffffff);
    random_phase(45);
    set_config($urandom(), 4'd8, 16'd0, 24'hffffff);
    random_phase(45);
    set_config(32'h7fffffff, 4'd9, 16'hffff, 24'd65536);
    random_phase(45);
    // random settings; the sender pauses for every result between phases
    repeat (6) begin
      set_config($urandom(), 4'($urandom_range(0, 15)), 16'($urandom()),
                 24'($urandom()));
      random_phase(45);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed && noise_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
